// ===== rtl/bedc_pkg.sv =====
`default_nettype none

package bedc_pkg;

  // Longest string kept per side
  localparam int unsigned MAX_LEN = 32;

  // Widths derived from the string length
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned COST_W = LEN_W;

  // Fixed field widths
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DIST_W = 6;
  localparam int unsigned CMP_W  = (COST_W > DIST_W) ? COST_W : DIST_W;

  // Largest value the distance field can show
  localparam logic [DIST_W-1:0] DIST_FIELD_MAX = '1;

  // Input beat kinds carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST  = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // Control sequencer, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_TAIL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/bedc_ram.sv =====
`default_nettype none

module bedc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_edit_distance_check_core.sv =====
`default_nettype none

// Levenshtein distance checker. Load beats (tuser 0: first string, 1: second
// string) are taken one per cycle while idle and append the byte on tdata; a
// string that is offered more than MAX_LEN bytes keeps its first MAX_LEN and
// flags overflow. An evaluate beat (tuser 2) runs the row-by-row recurrence
// through the cost-row memory, one cell per cycle: each row opens with a fetch
// state and then sweeps its cells, each taking its left neighbor from the cell
// before; a tail state follows the last row, and an empty string goes straight
// to the result. A result still waiting on the master side holds the sequencer
// until it is taken. One result beat then gives within, distance and overflow,
// and both strings are cleared. Load beats are accepted while a result waits
// on the master side; tuser 3 is dropped.
module bounded_edit_distance_check_core
  import bedc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // slave side
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] symbol
  input  wire logic [1:0]        s_axis_tuser,   // [1:0] mode
  // master side
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [7:0]        m_axis_tdata,   // [0] within_res, [6:1] distance, [7] overflow
  // configuration
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [DIST_W-1:0] cfg_data_i      // max_distance
);

  state_e state_q, state_d;

  logic [DIST_W-1:0] max_dist_q;
  logic [LEN_W-1:0]  first_len_q, second_len_q;
  logic              too_long_q;

  logic [ADDR_W-1:0] row_q, col_q;
  logic              ex_valid_q;
  logic [ADDR_W-1:0] ex_col_q;
  logic              ex_first_q;
  logic [COST_W-1:0] left_q, diag_q, dist_q;

  logic              out_valid_q;
  logic [7:0]        out_data_q;

  logic [SYM_W-1:0]  a_sym, b_sym;
  logic [COST_W-1:0] cost_rdata, up_cost, new_cost, min_ud, min_all;

  logic              in_beat, cfg_beat, out_free;
  mode_e             in_mode;
  logic              first_full, second_full;
  logic              col_last, row_last;
  logic [CMP_W-1:0]  dist_cmp, max_cmp;
  logic [DIST_W-1:0] dist_shown;

  assign in_beat   = s_axis_tvalid & s_axis_tready;
  assign cfg_beat  = cfg_valid_i & cfg_ready_o;
  assign in_mode   = mode_e'(s_axis_tuser);
  assign out_free  = ~out_valid_q | m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign first_full  = (first_len_q == LEN_W'(MAX_LEN));
  assign second_full = (second_len_q == LEN_W'(MAX_LEN));
  assign col_last    = ((LEN_W'(col_q) + 1'b1) == second_len_q);
  assign row_last    = ((LEN_W'(row_q) + 1'b1) == first_len_q);

  // Symbol and cost storage
  bedc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (in_beat && in_mode == MODE_FIRST && !first_full),
    .waddr_i (first_len_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (state_q == ST_FETCH),
    .raddr_i (row_q),
    .rdata_o (a_sym)
  );

  bedc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (in_beat && in_mode == MODE_SECOND && !second_full),
    .waddr_i (second_len_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (state_q == ST_SWEEP),
    .raddr_i (col_q),
    .rdata_o (b_sym)
  );

  // Entry j-1 holds the cost of column j; column 0 is the row index itself
  bedc_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (ex_valid_q),
    .waddr_i (ex_col_q),
    .wdata_i (new_cost),
    .re_i    (state_q == ST_SWEEP),
    .raddr_i (col_q),
    .rdata_o (cost_rdata)
  );

  // DP cell: the row above is implicit (j) on the first row
  always_comb begin
    up_cost  = ex_first_q ? (COST_W'(ex_col_q) + 1'b1) : cost_rdata;
    min_ud   = (up_cost < diag_q) ? up_cost : diag_q;
    min_all  = (left_q < min_ud) ? left_q : min_ud;
    new_cost = (a_sym == b_sym) ? diag_q : (min_all + 1'b1);
  end

  // Result fields
  always_comb begin
    dist_cmp   = CMP_W'(dist_q);
    max_cmp    = CMP_W'(max_dist_q);
    dist_shown = (dist_cmp > CMP_W'(DIST_FIELD_MAX)) ? DIST_FIELD_MAX : DIST_W'(dist_q);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && in_mode == MODE_EVAL) begin
          if (first_len_q == '0 || second_len_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (col_last) begin
          state_d = row_last ? ST_TAIL : ST_FETCH;
        end
      end
      ST_TAIL:  state_d = ST_DONE;
      ST_DONE:  begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= DIST_W'(1);
    end else if (cfg_beat) begin
      max_dist_q <= cfg_data_i;
    end
  end

  // String lengths and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      too_long_q   <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      too_long_q   <= 1'b0;
    end else if (in_beat) begin
      case (in_mode)
        MODE_FIRST: begin
          if (first_full) too_long_q <= 1'b1;
          else            first_len_q <= first_len_q + 1'b1;
        end
        MODE_SECOND: begin
          if (second_full) too_long_q <= 1'b1;
          else             second_len_q <= second_len_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Row and column walkers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE:  begin
          row_q <= '0;
          col_q <= '0;
        end
        ST_FETCH: col_q <= '0;
        ST_SWEEP: begin
          col_q <= col_q + 1'b1;
          if (col_last) row_q <= row_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Execute stage follows each issued column in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= (state_q == ST_SWEEP);
    end
  end

  // Column and first-row mark travel with the cell
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SWEEP) begin
      ex_col_q   <= col_q;
      ex_first_q <= (row_q == '0);
    end
  end

  // Left and diagonal neighbors; row start overrides the last cell's update
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      left_q <= COST_W'(row_q) + 1'b1;
      diag_q <= COST_W'(row_q);
    end else if (ex_valid_q) begin
      left_q <= new_cost;
      diag_q <= up_cost;
    end
  end

  // Distance: last computed cell, or the other length when one string is empty
  always_ff @(posedge clk_i) begin
    if (in_beat && in_mode == MODE_EVAL) begin
      dist_q <= COST_W'(first_len_q | second_len_q);
    end else if (ex_valid_q) begin
      dist_q <= new_cost;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= {too_long_q, dist_shown, (!too_long_q && dist_cmp <= max_cmp)};
    end
  end

endmodule

`default_nettype wire
